/* design/earliest_free_worker_scheduler_defines.svh */
// Assertion macros for the verification file of the scheduler.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_DEFINES_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EFWS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EFWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/efws_pkg.sv */
// Package for the earliest-free-worker scheduler: widths, defaults and types.
// No dependencies; used by every module of the block.
package efws_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam int TIME_W          = 48;
    localparam int DUR_W           = 32;
    localparam int WIDX_W          = 4;
    localparam int CFG_W           = 5;

    localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(16);

    typedef enum logic [0:0] {
        ST_SELECT,
        ST_INSERT
    } state_t;

    typedef struct packed {
        logic capture;
        logic insert;
    } cell_ctrl_t;

endpackage

/* design/efws_cell.sv */
// One cell of the sorted worker chain: holds one (free time, worker index) entry.
// Depends on efws_pkg; instantiated in a row by earliest_free_worker_scheduler.
module efws_cell #(
    parameter int IDX_W   = 4,
    parameter int CNT_W   = 5,
    parameter int CELL_ID = 0,
    parameter bit LAST    = 1'b0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  efws_pkg::cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]           count_eff,
    input  logic                       found_in,
    input  logic [efws_pkg::TIME_W-1:0] right_time,
    input  logic [IDX_W-1:0]           right_idx,
    input  logic [efws_pkg::TIME_W-1:0] new_time,
    input  logic [IDX_W-1:0]           new_idx,
    output logic                       found_out,
    output logic                       pick,
    output logic [efws_pkg::TIME_W-1:0] time_q,
    output logic [IDX_W-1:0]           idx_q
);
    import efws_pkg::*;

    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              ge_reg;
    logic              head_reg;
    logic              active;
    logic              right_less;
    logic              own_less;

    assign active    = (CNT_W'(idx_reg) < count_eff);
    assign pick      = active && !found_in;
    assign found_out = found_in || active;
    assign time_q    = time_reg;
    assign idx_q     = idx_reg;

    assign right_less = !LAST && ((right_time < new_time) ||
                                  ((right_time == new_time) && (right_idx < new_idx)));
    assign own_less   = (time_reg < new_time) ||
                        ((time_reg == new_time) && (idx_reg < new_idx));

    always_comb
    begin
        time_next = time_reg;
        idx_next  = idx_reg;
        if (ctrl.insert && ge_reg)
        begin
            if (right_less)
            begin
                time_next = right_time;
                idx_next  = right_idx;
            end
            else if (head_reg || own_less)
            begin
                time_next = new_time;
                idx_next  = new_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            idx_reg  <= IDX_W'(CELL_ID);
            ge_reg   <= 1'b0;
            head_reg <= 1'b0;
        end
        else
        begin
            time_reg <= time_next;
            idx_reg  <= idx_next;
            if (ctrl.capture)
            begin
                ge_reg   <= found_out;
                head_reg <= pick;
            end
        end
    end

endmodule

/* design/earliest_free_worker_scheduler.sv */
// The result beat is valid in the cycle after its job beat is accepted.
// No job is taken during reinsertion; the cell chain selects the head in the
// accept cycle and moves the chosen worker to its new sorted place in the next.
// Reset: all free times are zero, the chain holds workers in index order, and
// the worker count is 16. The block takes a job in the first cycle after reset.
module earliest_free_worker_scheduler #(
    parameter int MAX_WORKERS = efws_pkg::MAX_WORKERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [efws_pkg::CFG_W-1:0]  cfg_write_data,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  logic [efws_pkg::DUR_W-1:0]  job_duration,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [efws_pkg::WIDX_W-1:0] worker_index,
    output logic [efws_pkg::TIME_W-1:0] start_time
);
    import efws_pkg::*;

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);

    state_t             state_reg;
    state_t             state_next;
    cell_ctrl_t         ctrl;
    logic               job_accept;

    logic [CFG_W-1:0]   worker_count_reg;
    logic [CNT_W-1:0]   count_eff;

    logic [TIME_W-1:0]  cell_time [MAX_WORKERS];
    logic [IDX_W-1:0]   cell_idx [MAX_WORKERS];
    logic [MAX_WORKERS:0] found_chain;
    logic [MAX_WORKERS-1:0] pick;

    logic [TIME_W-1:0]  sel_time;
    logic [IDX_W-1:0]   sel_idx;
    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  sum_sat;

    logic [TIME_W-1:0]  new_time_reg;
    logic [IDX_W-1:0]   new_idx_reg;

    logic               result_valid_reg;
    logic [WIDX_W-1:0]  worker_index_reg;
    logic [TIME_W-1:0]  start_time_reg;

    always_comb
    begin
        if (worker_count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (32'(worker_count_reg) > MAX_WORKERS)
        begin
            count_eff = CNT_W'(MAX_WORKERS);
        end
        else
        begin
            count_eff = CNT_W'(worker_count_reg);
        end
    end

    assign found_chain[0] = 1'b0;

    for (genvar g = 0; g < MAX_WORKERS; g++)
    begin : g_cell
        logic [TIME_W-1:0] r_time;
        logic [IDX_W-1:0]  r_idx;

        if (g == MAX_WORKERS - 1)
        begin : g_last
            assign r_time = '0;
            assign r_idx  = '0;
        end
        else
        begin : g_mid
            assign r_time = cell_time[g+1];
            assign r_idx  = cell_idx[g+1];
        end

        efws_cell #(
            .IDX_W   (IDX_W),
            .CNT_W   (CNT_W),
            .CELL_ID (g),
            .LAST    (g == MAX_WORKERS - 1)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count_eff  (count_eff),
            .found_in   (found_chain[g]),
            .right_time (r_time),
            .right_idx  (r_idx),
            .new_time   (new_time_reg),
            .new_idx    (new_idx_reg),
            .found_out  (found_chain[g+1]),
            .pick       (pick[g]),
            .time_q     (cell_time[g]),
            .idx_q      (cell_idx[g])
        );
    end

    always_comb
    begin
        sel_time = '0;
        sel_idx  = '0;
        for (int i = 0; i < MAX_WORKERS; i++)
        begin
            sel_time = sel_time | (cell_time[i] & {TIME_W{pick[i]}});
            sel_idx  = sel_idx | (cell_idx[i] & {IDX_W{pick[i]}});
        end
    end

    assign sum     = {1'b0, sel_time} + (TIME_W + 1)'(job_duration);
    assign sum_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    assign job_accept = job_valid && job_ready;

    always_comb
    begin
        state_next   = state_reg;
        job_ready    = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.insert  = 1'b0;
        unique case (state_reg)
            ST_SELECT:
            begin
                job_ready    = !result_valid_reg || result_ready;
                ctrl.capture = job_valid && job_ready;
                if (job_valid && job_ready)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                ctrl.insert = 1'b1;
                state_next  = ST_SELECT;
            end
            default:
            begin
                state_next = ST_SELECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SELECT;
            worker_count_reg <= COUNT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                worker_count_reg <= cfg_write_data;
            end
            if (job_accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_accept)
        begin
            new_time_reg     <= sum_sat;
            new_idx_reg      <= sel_idx;
            worker_index_reg <= WIDX_W'(sel_idx);
            start_time_reg   <= sel_time;
        end
    end

    assign result_valid = result_valid_reg;
    assign worker_index = worker_index_reg;
    assign start_time   = start_time_reg;

endmodule

/* design/efws_checker.sv */
// Port-level checks for the earliest-free-worker scheduler, bound to its top level.
// Depends on efws_pkg and the assertion macros in the defines header.
`include "earliest_free_worker_scheduler_defines.svh"

module efws_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        job_valid,
    input logic                        job_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [efws_pkg::WIDX_W-1:0] worker_index,
    input logic [efws_pkg::TIME_W-1:0] start_time
);
    // A stalled result beat must hold its payload.
    `EFWS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(worker_index) && $stable(start_time), "result beat changed while stalled")
    // The chain needs the cycle after an accepted job to reinsert the worker.
    `EFWS_ASSERT_NEXT(a_job_gap, job_valid && job_ready, !job_ready, "job accepted during reinsertion")
    // Every accepted job produces a result beat in the next cycle.
    `EFWS_ASSERT_NEXT(a_result_follows, job_valid && job_ready, result_valid, "no result after accepted job")
    // A new result beat appears only after an accepted job.
    `EFWS_ASSERT_IMPLY(a_no_spurious, $rose(result_valid), $past(job_valid && job_ready), "result beat without a job")

endmodule

bind earliest_free_worker_scheduler efws_checker u_efws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .worker_index (worker_index),
    .start_time   (start_time)
);
